// File: design/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and opcodes for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

	// opcodes
	typedef enum logic [3:0] {
		CMD_INT2FIX = 4'd0,
		CMD_TRUNC   = 4'd1,
		CMD_ROUND   = 4'd2,
		CMD_ADD     = 4'd3,
		CMD_SUB     = 4'd4,
		CMD_ADDINT  = 4'd5,
		CMD_SUBINT  = 4'd6,
		CMD_MUL     = 4'd7,
		CMD_MULINT  = 4'd8,
		CMD_DIV     = 4'd9,
		CMD_DIVINT  = 4'd10
	} cmd_t;

	// request transaction
	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	// response transaction
	typedef struct packed {
		logic signed [31:0] value_out;
		logic               divide_by_zero;
	} rsp_t;

	// per-stage control that travels with the data
	typedef struct packed {
		logic valid;
		logic mul_op;
		logic mulint_op;
		logic div_op;
		logic dz;
		logic neg;
	} ctl_t;

endpackage

// File: design/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Second stage: simple ops, signed product and divider setup, registered.
// ----------------------------------------------------------------------------
module fpa_front #(
	parameter int W = 32,
	parameter int F = 14,
	parameter int Q = 46
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_s1,
	input  logic [3:0]           cmd_s1,
	input  logic [W-1:0]         a_s1,
	input  logic [W-1:0]         b_s1,
	output fpa_pkg::ctl_t        ctl_s2,
	output logic [2*W-1:0]       prod_s2,
	output logic [W-1:0]         val_s2,
	output logic [Q-1:0]         num_s2,
	output logic [W-1:0]         den_s2
);

	logic signed [63:0]    a64;
	logic signed [63:0]    b64;
	logic signed [63:0]    one;
	logic signed [63:0]    half;
	logic signed [63:0]    v;
	logic signed [W-1:0]   sa;
	logic signed [W-1:0]   sb;
	logic signed [2*W-1:0] prod;
	logic [W-1:0]          a_mag;
	logic [W-1:0]          b_mag;
	fpa_pkg::ctl_t         ctl;

	assign sa   = signed'(a_s1);
	assign sb   = signed'(b_s1);
	assign a64  = 64'(sa);
	assign b64  = 64'(sb);
	assign one  = 64'sd1 <<< F;
	assign half = one >>> 1;
	assign prod = sa * sb;

	// simple operations in wide signed arithmetic
	always_comb begin
		case (cmd_s1)
			fpa_pkg::CMD_INT2FIX: v = b64 <<< F;
			fpa_pkg::CMD_TRUNC:   v = ((a64 < 0) ? (a64 + one - 64'sd1) : a64) >>> F;
			fpa_pkg::CMD_ROUND: begin
				if (a64 >= 0) v = (a64 + half) >>> F;
				else          v = -(((-a64) + half) >>> F);
			end
			fpa_pkg::CMD_ADD:     v = a64 + b64;
			fpa_pkg::CMD_SUB:     v = a64 - b64;
			fpa_pkg::CMD_ADDINT:  v = a64 + (b64 <<< F);
			fpa_pkg::CMD_SUBINT:  v = a64 - (b64 <<< F);
			default:              v = 64'sd0;
		endcase
	end

	// divider setup on magnitudes
	assign a_mag = a_s1[W-1] ? (~a_s1 + 1'b1) : a_s1;
	assign b_mag = b_s1[W-1] ? (~b_s1 + 1'b1) : b_s1;

	always_comb begin
		ctl.valid     = valid_s1;
		ctl.mul_op    = (cmd_s1 == fpa_pkg::CMD_MUL);
		ctl.mulint_op = (cmd_s1 == fpa_pkg::CMD_MULINT);
		ctl.div_op    = (cmd_s1 == fpa_pkg::CMD_DIV) || (cmd_s1 == fpa_pkg::CMD_DIVINT);
		ctl.dz        = ctl.div_op && (b_s1 == '0);
		ctl.neg       = a_s1[W-1] ^ b_s1[W-1];
	end

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod;
			val_s2  <= v[W-1:0];
			num_s2  <= (cmd_s1 == fpa_pkg::CMD_DIV) ? (Q'(a_mag) << F) : Q'(a_mag);
			den_s2  <= b_mag;
		end
	end

endmodule

// File: design/fpa_div_step.sv
// ----------------------------------------------------------------------------
// fpa_div_step
// One registered restoring-division step; other results ride along.
// ----------------------------------------------------------------------------
module fpa_div_step #(
	parameter int W = 32,
	parameter int Q = 46
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  fpa_pkg::ctl_t ctl_i,
	input  logic [W-1:0]  rem_i,
	input  logic [Q-1:0]  num_i,
	input  logic [W-1:0]  den_i,
	input  logic [W-1:0]  val_i,
	output fpa_pkg::ctl_t ctl_o,
	output logic [W-1:0]  rem_o,
	output logic [Q-1:0]  num_o,
	output logic [W-1:0]  den_o,
	output logic [W-1:0]  val_o
);

	logic [W:0]   shifted;
	logic [W+1:0] diff;
	logic         ge;

	// trial subtract of the divisor
	assign shifted = {rem_i, num_i[Q-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_i};
	assign ge      = !diff[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[W-1:0] : shifted[W-1:0];
			num_o <= {num_i[Q-2:0], ge};
			den_o <= den_i;
			val_o <= val_i;
		end
	end

endmodule

// File: design/fixed_point_17_14_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu
// Pipelined signed fixed-point ALU with a one-bit-per-stage divider.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | fpa_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_stall  | fpa_pkg::rsp_t
//
// Takes one transaction per cycle while no rsp stall holds the pipeline;
// the divider chain computes one quotient bit a stage.
// Reset clears all stage valid bits; payload registers are not reset.
// A stall on rsp with a result waiting freezes every stage and raises
// req_stall in the same cycle.
// ----------------------------------------------------------------------------
module fixed_point_17_14_alu #(
	parameter int FRAC_BITS = 14,
	parameter int WORD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fpa_pkg::rsp_t rsp
);

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int Q = W + F;

	logic                  en;
	logic                  valid_s1;
	logic [3:0]            cmd_s1;
	logic [W-1:0]          a_s1;
	logic [W-1:0]          b_s1;
	fpa_pkg::ctl_t         ctl_s2;
	logic [2*W-1:0]        prod_s2;
	logic [W-1:0]          val_s2;
	logic [Q-1:0]          num_s2;
	logic [W-1:0]          den_s2;
	logic signed [63:0]    p64;
	logic signed [63:0]    padj;
	logic [W-1:0]          val_mix;
	fpa_pkg::ctl_t         ctl_c [Q+1];
	logic [W-1:0]          rem_c [Q+1];
	logic [Q-1:0]          num_c [Q+1];
	logic [W-1:0]          den_c [Q+1];
	logic [W-1:0]          val_c [Q+1];
	logic [Q-1:0]          q_signed;
	logic [W-1:0]          v_fin;
	logic                  rsp_valid_q;
	fpa_pkg::rsp_t         rsp_q;

	// global advance, held only by a waiting result
	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= req.cmd;
			a_s1   <= req.operand_a[W-1:0];
			b_s1   <= req.operand_b[W-1:0];
		end
	end

	fpa_front #(.W(W), .F(F), .Q(Q)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1),
		.a_s1     (a_s1),
		.b_s1     (b_s1),
		.ctl_s2   (ctl_s2),
		.prod_s2  (prod_s2),
		.val_s2   (val_s2),
		.num_s2   (num_s2),
		.den_s2   (den_s2)
	);

	// product scaling, truncating toward zero
	assign p64  = 64'(signed'(prod_s2));
	assign padj = (p64 + ((p64 < 0) ? ((64'sd1 <<< F) - 64'sd1) : 64'sd0)) >>> F;

	always_comb begin
		if (ctl_s2.mul_op)         val_mix = padj[W-1:0];
		else if (ctl_s2.mulint_op) val_mix = prod_s2[W-1:0];
		else                       val_mix = val_s2;
	end

	// third stage, head of the divider chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else if (en) begin
			ctl_c[0] <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_c[0] <= '0;
			num_c[0] <= num_s2;
			den_c[0] <= den_s2;
			val_c[0] <= val_mix;
		end
	end

	// divider chain, one quotient bit per stage
	for (genvar k = 0; k < Q; k++) begin : g_step
		fpa_div_step #(.W(W), .Q(Q)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (ctl_c[k]),
			.rem_i  (rem_c[k]),
			.num_i  (num_c[k]),
			.den_i  (den_c[k]),
			.val_i  (val_c[k]),
			.ctl_o  (ctl_c[k+1]),
			.rem_o  (rem_c[k+1]),
			.num_o  (num_c[k+1]),
			.den_o  (den_c[k+1]),
			.val_o  (val_c[k+1])
		);
	end

	// sign fix and result select
	assign q_signed = ctl_c[Q].neg ? (~num_c[Q] + 1'b1) : num_c[Q];

	always_comb begin
		if (!ctl_c[Q].div_op) v_fin = val_c[Q];
		else if (ctl_c[Q].dz) v_fin = '0;
		else                  v_fin = q_signed[W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= ctl_c[Q].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.value_out      <= 32'(signed'(v_fin));
			rsp_q.divide_by_zero <= ctl_c[Q].div_op && ctl_c[Q].dz;
		end
	end

`ifndef SYNTH
	// zero divisor always gives a zero value
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.divide_by_zero || rsp.value_out == 32'sd0))
		else $error("divide_by_zero with nonzero value");

	// input is held back only by a waiting result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == (rsp_valid && rsp_stall))
		else $error("req_stall without output back pressure");

	// a frozen pipeline keeps the valids at the head and tail of the divider chain
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |=> ($stable(ctl_c[0].valid) && $stable(ctl_c[Q].valid)))
		else $error("stage valid changed during stall");

	// zero-divisor mark only on division ops
	a_dz_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[0].dz |-> ctl_c[0].div_op)
		else $error("zero-divisor mark on non-division op");
`endif

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 17.14 fixed-point ALU: directed corner cases,
// then random transactions over every opcode, with random request gaps and
// response stalls. Each response is compared to a queue of predicted results.
// ----------------------------------------------------------------------------
module testbench;

	localparam int FRAC = 14;
	localparam int LATENCY = 49;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	fpa_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_stall;
	fpa_pkg::rsp_t  rsp;

	fpa_pkg::rsp_t  expected_q[$];
	int             error_count;
	logic           stall_busy;

	fixed_point_17_14_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// compute the expected result of one transaction
	function automatic fpa_pkg::rsp_t alu_result(logic [3:0] op, logic signed [31:0] a32,
			logic signed [31:0] b32);
		longint        a;
		longint        b;
		longint        r;
		longint        one;
		fpa_pkg::rsp_t res;
		a = a32;
		b = b32;
		one = longint'(1) << FRAC;
		r = 0;
		res.divide_by_zero = 1'b0;
		case (op)
			fpa_pkg::CMD_INT2FIX: r = b * one;
			fpa_pkg::CMD_TRUNC:   r = a / one;
			fpa_pkg::CMD_ROUND:   r = (a >= 0) ? (a + one / 2) / one : (a - one / 2) / one;
			fpa_pkg::CMD_ADD:     r = a + b;
			fpa_pkg::CMD_SUB:     r = a - b;
			fpa_pkg::CMD_ADDINT:  r = a + b * one;
			fpa_pkg::CMD_SUBINT:  r = a - b * one;
			fpa_pkg::CMD_MUL:     r = (a * b) / one;
			fpa_pkg::CMD_MULINT:  r = a * b;
			fpa_pkg::CMD_DIV: begin
				if (b == 0) res.divide_by_zero = 1'b1;
				else r = (a * one) / b;
			end
			fpa_pkg::CMD_DIVINT: begin
				if (b == 0) res.divide_by_zero = 1'b1;
				else r = a / b;
			end
			default: r = 0;
		endcase
		res.value_out = r[31:0];
		return res;
	endfunction

	// mismatch report
	task automatic report_error(string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// random gap length: mostly short, sometimes long
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// send one transaction and record its prediction
	task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		repeat (g) @(posedge clk);
		req_valid <= 1'b1;
		req.cmd <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_q.push_back(alu_result(op, a, b));
		// keep valid high if the next call sends at once; lowered by caller
	endtask

	task automatic idle_req();
		req_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return $urandom_range(0, 65535) - 32768;
			4: return ($urandom_range(0, 2047) - 1024) << FRAC;
			5: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// response stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (stall_busy) begin
			rsp_stall <= ($urandom_range(0, 99) < 30);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				report_error("response with nothing expected");
			end else begin
				if (rsp.value_out !== expected_q[0].value_out)
					report_error($sformatf("value_out got %h exp %h",
						rsp.value_out, expected_q[0].value_out));
				if (rsp.divide_by_zero !== expected_q[0].divide_by_zero)
					report_error($sformatf("divide_by_zero got %b exp %b",
						rsp.divide_by_zero, expected_q[0].divide_by_zero));
				void'(expected_q.pop_front());
			end
		end
	end

	// directed corners: every opcode, extremes, zero divisor, quotient overflow
	task automatic test_directed();
		logic [31:0] corners[5];
		corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_6000};
		for (int op = 0; op <= 10; op++)
			send_op(op[3:0], corners[op % 5], corners[(op + 2) % 5], 1'b0);
		send_op(fpa_pkg::CMD_DIV, 32'h0001_0000, 32'h0, 1'b0);
		send_op(fpa_pkg::CMD_DIVINT, 32'h8000_0000, 32'h0, 1'b0);
		send_op(fpa_pkg::CMD_DIVINT, 32'h8000_0000, 32'hffff_ffff, 1'b0);
		send_op(fpa_pkg::CMD_ROUND, 32'h0000_2000, 32'h0, 1'b0);
		send_op(fpa_pkg::CMD_ROUND, 32'hffff_e000, 32'h0, 1'b0);
		send_op(fpa_pkg::CMD_TRUNC, 32'hffff_c001, 32'h0, 1'b0);
		send_op(fpa_pkg::CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_op(fpa_pkg::CMD_MULINT, 32'h8000_0000, 32'hffff_ffff, 1'b0);
		send_op(4'd11, 32'h1234_5678, 32'h1, 1'b0);
		send_op(4'd15, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		idle_req();
	endtask

	// random transactions with gaps and response stalls
	task automatic test_random();
		logic [3:0] op;
		int         g;
		stall_busy = 1'b1;
		for (int i = 0; i < 1100; i++) begin
			op = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(11, 15))
				: 4'($urandom_range(0, 10));
			g = gap_len();
			if (g != 0) begin
				idle_req();
				repeat (g) @(posedge clk);
			end
			send_op(op, rand_operand(),
				($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand(), 1'b0);
		end
		idle_req();
		// a stretch with stalls only, then drain freely
		repeat (200) @(posedge clk);
		stall_busy = 1'b0;
	endtask

	// limit
	initial begin
		#3000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		error_count = 0;
		stall_busy = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
